// ----- hdl/ilp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, character codes and digit decoding for the integer literal parser.
// No dependencies.
package ilp_pkg;

	localparam int MagWidth   = 63;
	localparam int ValueWidth = 64;
	localparam int ErrWidth   = 3;

	localparam logic [7:0] ChrZero  = 8'h30;
	localparam logic [7:0] ChrNine  = 8'h39;
	localparam logic [7:0] ChrLowA  = 8'h61;
	localparam logic [7:0] ChrLowF  = 8'h66;
	localparam logic [7:0] ChrUpA   = 8'h41;
	localparam logic [7:0] ChrUpF   = 8'h46;
	localparam logic [7:0] ChrLowX  = 8'h78;
	localparam logic [7:0] ChrLowO  = 8'h6f;
	localparam logic [7:0] ChrLowB  = 8'h62;
	localparam logic [7:0] ChrUnder = 8'h5f;
	localparam logic [7:0] ChrMinus = 8'h2d;
	localparam logic [7:0] ChrPlus  = 8'h2b;

	localparam logic [ErrWidth-1:0] ErrNone       = 3'd0;
	localparam logic [ErrWidth-1:0] ErrLeadZero   = 3'd1;
	localparam logic [ErrWidth-1:0] ErrUnderscore = 3'd2;
	localparam logic [ErrWidth-1:0] ErrBadDigit   = 3'd3;
	localparam logic [ErrWidth-1:0] ErrOverflow   = 3'd4;

	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_HEX = 2'd1,
		BASE_OCT = 2'd2,
		BASE_BIN = 2'd3
	} base_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} req_t;

	typedef struct packed {
		logic signed [ValueWidth-1:0] int_value;
		logic [ErrWidth-1:0]          error_code;
	} res_t;

	// bit 4: digit is valid in base; bits 3:0: digit value
	function automatic logic [4:0] digit_of(input logic [7:0] c, input base_t base);
		logic [4:0] d;
		logic [4:0] lim;
		d = 5'd31;
		if (c >= ChrZero && c <= ChrNine) begin
			d = 5'(c - ChrZero);
		end else if (c >= ChrLowA && c <= ChrLowF) begin
			d = 5'(c - ChrLowA) + 5'd10;
		end else if (c >= ChrUpA && c <= ChrUpF) begin
			d = 5'(c - ChrUpA) + 5'd10;
		end
		unique case (base)
			BASE_DEC: lim = 5'd10;
			BASE_HEX: lim = 5'd16;
			BASE_OCT: lim = 5'd8;
			BASE_BIN: lim = 5'd2;
			default:  lim = 5'd10;
		endcase
		return (d < lim) ? {1'b1, d[3:0]} : 5'd0;
	endfunction

endpackage

// ----- hdl/ilp_in_reg.sv -----
`timescale 1ns / 1ps
// Input register for character requests with its valid/stall handshake.
// Depends on ilp_pkg.
module ilp_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ilp_pkg::req_t req,
	input  logic          out_free,
	output logic          step,
	output ilp_pkg::req_t req_s1
);
	import ilp_pkg::*;

	logic valid_s1;
	logic accept;

	// a final character needs room in the result register
	assign step     = valid_s1 && (!req_s1.last_char || out_free);
	assign in_stall = valid_s1 && !step;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

endmodule

// ----- hdl/ilp_core.sv -----
`timescale 1ns / 1ps
// Parse state and the per-character update: prefix, digit check, accumulate, overflow.
// Depends on ilp_pkg.
module ilp_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  ilp_pkg::req_t req_s1,
	output logic          res_load,
	output ilp_pkg::res_t res
);
	import ilp_pkg::*;

	typedef enum logic [1:0] {
		PH_START  = 2'd0,
		PH_SIGN   = 2'd1,
		PH_ZERO   = 2'd2,
		PH_DIGITS = 2'd3
	} phase_t;

	phase_t              phase_q, phase_d;
	logic                neg_q, neg_d;
	base_t               base_q, base_d;
	logic [MagWidth-1:0] mag_q, mag_d;
	logic [ErrWidth-1:0] err_q, err_d;
	logic                first_q, first_d;

	logic [7:0]          c;
	logic                last;
	logic [4:0]          dig;
	logic [MagWidth+4:0] wide;
	logic [MagWidth+4:0] acc;
	logic                is_sign;
	logic                take;
	logic [ValueWidth-1:0] mag_ext;

	assign c       = req_s1.char_code;
	assign last    = req_s1.last_char;
	assign dig     = digit_of(c, base_q);
	assign is_sign = (c == ChrMinus) || (c == ChrPlus);

	always_comb begin
		unique case (base_q)
			BASE_DEC: wide = ({5'd0, mag_q} << 3) + ({5'd0, mag_q} << 1);
			BASE_HEX: wide = {5'd0, mag_q} << 4;
			BASE_OCT: wide = {5'd0, mag_q} << 3;
			BASE_BIN: wide = {5'd0, mag_q} << 1;
			default:  wide = {5'd0, mag_q};
		endcase
		acc = wide + {{(MagWidth+1){1'b0}}, dig[3:0]};
	end

	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		base_d  = base_q;
		mag_d   = mag_q;
		err_d   = err_q;
		first_d = first_q;
		take    = 1'b0;
		if (err_q == ErrNone) begin
			unique case (phase_q)
				PH_START, PH_SIGN: begin
					if (phase_q == PH_START && is_sign) begin
						neg_d   = (c == ChrMinus);
						phase_d = PH_SIGN;
					end else if (c == ChrZero && !last) begin
						phase_d = PH_ZERO;
					end else begin
						take = 1'b1;
					end
				end
				PH_ZERO: begin
					phase_d = PH_DIGITS;
					first_d = 1'b1;
					if (c == ChrLowX) begin
						base_d = BASE_HEX;
					end else if (c == ChrLowO) begin
						base_d = BASE_OCT;
					end else if (c == ChrLowB) begin
						base_d = BASE_BIN;
					end else begin
						phase_d = PH_ZERO;
						first_d = first_q;
						err_d   = ErrLeadZero;
					end
				end
				PH_DIGITS: take = 1'b1;
				default:   take = 1'b1;
			endcase
		end
		if (take) begin
			first_d = 1'b0;
			phase_d = PH_DIGITS;
			priority if (c == ChrUnder) begin
				if (first_q || last) begin
					err_d = ErrUnderscore;
				end
			end else if (!dig[4]) begin
				err_d = ErrBadDigit;
			end else if (acc[MagWidth+4:MagWidth] != 5'd0) begin
				err_d = ErrOverflow;
			end else begin
				mag_d = acc[MagWidth-1:0];
			end
		end
	end

	assign mag_ext  = {1'b0, mag_d};
	assign res_load = step && last;

	always_comb begin
		res.error_code = err_d;
		if (err_d != ErrNone) begin
			res.int_value = '0;
		end else if (neg_d) begin
			res.int_value = ValueWidth'(-mag_ext);
		end else begin
			res.int_value = mag_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			base_q  <= BASE_DEC;
			mag_q   <= '0;
			err_q   <= ErrNone;
			first_q <= 1'b1;
		end else if (step) begin
			if (last) begin
				phase_q <= PH_START;
				neg_q   <= 1'b0;
				base_q  <= BASE_DEC;
				mag_q   <= '0;
				err_q   <= ErrNone;
				first_q <= 1'b1;
			end else begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				base_q  <= base_d;
				mag_q   <= mag_d;
				err_q   <= err_d;
				first_q <= first_d;
			end
		end
	end

endmodule

// ----- hdl/ilp_out_reg.sv -----
`timescale 1ns / 1ps
// Result register holding one parsed value until the downstream side takes it.
// Depends on ilp_pkg.
module ilp_out_reg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     res_load,
	input  ilp_pkg::res_t            res,
	output logic                     out_free,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [63:0]       int_value,
	output logic [2:0]               error_code
);
	import ilp_pkg::*;

	logic res_valid_q;
	res_t res_q;

	assign out_free   = !res_valid_q || !out_stall;
	assign out_valid  = res_valid_q;
	assign int_value  = res_q.int_value;
	assign error_code = res_q.error_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

endmodule

// ----- hdl/integer_literal_parser.sv -----
`timescale 1ns / 1ps
// Top level of the integer literal parser: input register, parse core, result register.
// Depends on ilp_pkg, ilp_in_reg, ilp_core, ilp_out_reg.

// Characters of one integer token enter one per request, one per cycle, with
// last_char set on the final one. Each character is registered on entry and
// folded into the parse state as it leaves the input register; the base
// multiply, digit add and overflow compare happen in that single state update.
// The result for a token is loaded into the result register as its final
// character leaves the input register, and is held on out_valid while
// out_stall is high; the input keeps taking characters meanwhile and stalls
// only when another final character finds the result register still occupied.
module integer_literal_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        char_code,
	input  logic              last_char,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [63:0] int_value,
	output logic [2:0]        error_code
);
	import ilp_pkg::*;

	req_t req;
	req_t req_s1;
	res_t res;
	logic step;
	logic out_free;
	logic res_load;

	assign req.char_code = char_code;
	assign req.last_char = last_char;

	ilp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req      (req),
		.out_free (out_free),
		.step     (step),
		.req_s1   (req_s1)
	);

	ilp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.req_s1   (req_s1),
		.res_load (res_load),
		.res      (res)
	);

	ilp_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_load   (res_load),
		.res        (res),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.int_value  (int_value),
		.error_code (error_code)
	);

endmodule

// ----- dv/ilp_value_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the integer literal parser: follows every accepted character,
// works out each token's value and error code, and compares them with the results.
// Depends on ilp_pkg.
module ilp_value_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [63:0] int_value,
	input  logic [2:0]         error_code,
	output int                 mismatch_count,
	output int                 tokens_open
);
	import ilp_pkg::*;

	typedef enum logic [1:0] {
		PH_START,
		PH_SIGNED,
		PH_ZERO,
		PH_DIGITS
	} phase_t;

	localparam logic [63:0] MagMax = 64'h7fff_ffff_ffff_ffff;

	phase_t              phase;
	logic                negative;
	base_t               radix;
	logic [63:0]         magnitude;
	logic [ErrWidth-1:0] first_err;
	logic                at_lead;
	res_t                due_results[$];
	res_t                due;
	int                  fails = 0;

	function automatic int radix_size(base_t b);
		case (b)
			BASE_HEX: return 16;
			BASE_OCT: return 8;
			BASE_BIN: return 2;
			default:  return 10;
		endcase
	endfunction

	function automatic int digit_value(logic [7:0] c, base_t b);
		int d;
		d = -1;
		if (c >= ChrZero && c <= ChrNine) begin
			d = int'(c) - int'(ChrZero);
		end else if (c >= ChrLowA && c <= ChrLowF) begin
			d = int'(c) - int'(ChrLowA) + 10;
		end else if (c >= ChrUpA && c <= ChrUpF) begin
			d = int'(c) - int'(ChrUpA) + 10;
		end
		return (d < radix_size(b)) ? d : -1;
	endfunction

	task automatic restart_token();
		phase = PH_START;
		negative = 1'b0;
		radix = BASE_DEC;
		magnitude = '0;
		first_err = ErrNone;
		at_lead = 1'b1;
	endtask

	task automatic note_error(input logic [ErrWidth-1:0] code);
		if (first_err == ErrNone) first_err = code;
	endtask

	task automatic fold_digit(input logic [7:0] c, input logic fin);
		logic        lead;
		int          d;
		logic [63:0] r;
		lead = at_lead;
		at_lead = 1'b0;
		phase = PH_DIGITS;
		if (c == ChrUnder) begin
			if (lead || fin) note_error(ErrUnderscore);
		end else begin
			d = digit_value(c, radix);
			r = 64'(radix_size(radix));
			if (d < 0) begin
				note_error(ErrBadDigit);
			end else if (magnitude > (MagMax - 64'(d)) / r) begin
				note_error(ErrOverflow);
			end else begin
				magnitude = magnitude * r + 64'(d);
			end
		end
	endtask

	task automatic parse_char(input logic [7:0] c, input logic fin);
		if (first_err == ErrNone) begin
			if (phase == PH_START && (c == ChrMinus || c == ChrPlus)) begin
				negative = (c == ChrMinus);
				phase = PH_SIGNED;
			end else if (phase == PH_START || phase == PH_SIGNED) begin
				if (c == ChrZero && !fin) phase = PH_ZERO;
				else fold_digit(c, fin);
			end else if (phase == PH_ZERO) begin
				case (c)
					ChrLowX: radix = BASE_HEX;
					ChrLowO: radix = BASE_OCT;
					ChrLowB: radix = BASE_BIN;
					default: note_error(ErrLeadZero);
				endcase
				if (first_err == ErrNone) begin
					phase = PH_DIGITS;
					at_lead = 1'b1;
				end
			end else begin
				fold_digit(c, fin);
			end
		end
		if (fin) begin
			if (first_err != ErrNone) due.int_value = '0;
			else if (negative) due.int_value = 64'd0 - magnitude;
			else due.int_value = magnitude;
			due.error_code = first_err;
			due_results.insert(due_results.size(), due);
			restart_token();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_token();
			due_results.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$error("int_value: expected no result, actual %0d (error_code %0d)",
						int_value, error_code);
					fails++;
				end else begin
					due = due_results.pop_front();
					if (int_value !== due.int_value) begin
						$error("int_value: expected %0d, actual %0d", due.int_value, int_value);
						fails++;
					end
					if (error_code !== due.error_code) begin
						$error("error_code: expected %0d, actual %0d", due.error_code, error_code);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall) parse_char(char_code, last_char);
		end
		tokens_open <= due_results.size();
		mismatch_count <= fails;
	end

endmodule

// ----- dv/tb_integer_literal_parser.sv -----
`timescale 1ns / 1ps
// Testbench top for the integer literal parser: clock, reset, token requests and
// result back-pressure; prediction and comparison sit in ilp_value_checker.
// Depends on ilp_pkg, integer_literal_parser, ilp_value_checker.
module tb_integer_literal_parser;
	import ilp_pkg::*;

	localparam int          CharBudget = 1100;
	localparam int          LongHold   = 300;
	localparam int          CycleLimit = 200000;
	localparam logic [63:0] MagMax     = 64'h7fff_ffff_ffff_ffff;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         char_code;
	logic               last_char;
	logic               out_valid;
	logic               out_stall;
	logic signed [63:0] int_value;
	logic [2:0]         error_code;
	int                 mismatch_count;
	int                 tokens_open;

	int         cycles = 0;
	int         chars_sent = 0;
	int         tokens_sent = 0;
	int         results_taken = 0;
	bit         paused = 1'b0;
	logic [7:0] token[$];

	integer_literal_parser DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.int_value  (int_value),
		.error_code (error_code)
	);

	ilp_value_checker value_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.last_char      (last_char),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.int_value      (int_value),
		.error_code     (error_code),
		.mismatch_count (mismatch_count),
		.tokens_open    (tokens_open)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("integer_literal_parser regression: fail");
			$finish;
		end
	end

	function automatic int radix_size(base_t b);
		case (b)
			BASE_HEX: return 16;
			BASE_OCT: return 8;
			BASE_BIN: return 2;
			default:  return 10;
		endcase
	endfunction

	function automatic logic [7:0] prefix_char(base_t b);
		case (b)
			BASE_HEX: return ChrLowX;
			BASE_OCT: return ChrLowO;
			default:  return ChrLowB;
		endcase
	endfunction

	function automatic logic [7:0] digit_char(int d);
		if (d < 10) return ChrZero + 8'(d);
		return ($urandom_range(0, 1) ? ChrLowA : ChrUpA) + 8'(d - 10);
	endfunction

	task automatic send_char(input logic [7:0] c, input logic fin);
		int gap;
		if ((tokens_sent / 8) % 3 == 1) gap = 0;
		else gap = $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		last_char <= fin;
		do @(posedge clk); while (in_stall);
		chars_sent++;
	endtask

	task automatic send_token();
		foreach (token[i]) send_char(token[i], i == token.size() - 1);
		tokens_sent++;
	endtask

	task automatic send_text(input string s);
		token.delete();
		for (int i = 0; i < s.len(); i++) token.insert(token.size(), s[i]);
		send_token();
	endtask

	// hold valid low until every predicted result has been taken
	task automatic await_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tokens_open != 0) @(posedge clk);
	endtask

	task automatic compose_token();
		int          kind;
		int          r;
		int          lead_pos;
		base_t       b;
		logic [63:0] v;
		logic [7:0]  body[$];
		token.delete();
		kind = $urandom_range(0, 99);
		if (kind < 25) begin
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 5))
					0: token.insert(token.size(), ChrUnder);
					1: token.insert(token.size(), ChrZero);
					2: token.insert(token.size(), $urandom_range(0, 1) ? ChrMinus : ChrPlus);
					3: token.insert(token.size(), prefix_char(base_t'($urandom_range(1, 3))));
					default: token.insert(token.size(), 8'($urandom_range(0, 255)));
				endcase
			end
		end else begin
			case ($urandom_range(0, 2))
				1: token.insert(token.size(), ChrMinus);
				2: token.insert(token.size(), ChrPlus);
				default: ;
			endcase
			b = base_t'($urandom_range(0, 3));
			r = radix_size(b);
			if (b != BASE_DEC) begin
				token.insert(token.size(), ChrZero);
				token.insert(token.size(), prefix_char(b));
			end
			lead_pos = token.size();
			if (kind < 37) begin
				case ($urandom_range(0, 4))
					0: v = {$urandom, $urandom};
					1: v = MagMax;
					2: v = MagMax + 64'd1;
					3: v = MagMax - 64'($urandom_range(0, 40));
					default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
				endcase
			end else begin
				v = 64'($urandom_range(0, 4000));
			end
			do begin
				body.push_front(digit_char(int'(v % 64'(r))));
				v = v / 64'(r);
			end while (v != 0);
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 2))
					body.insert(body.size(), digit_char($urandom_range(0, r - 1)));
			if (b != BASE_DEC && $urandom_range(0, 15) == 0) body.delete();
			foreach (body[i]) begin
				if (i > 0 && $urandom_range(0, 7) == 0)
					repeat ($urandom_range(1, 2)) token.insert(token.size(), ChrUnder);
				token.insert(token.size(), body[i]);
			end
			case ($urandom_range(0, 19))
				0: token.insert(token.size(), ChrUnder);
				1: token.insert(lead_pos, ChrUnder);
				2: token[$urandom_range(0, token.size() - 1)] = 8'($urandom_range(0, 255));
				3: token.insert(lead_pos, ChrZero);
				default: ;
			endcase
		end
	endtask

	initial begin
		int hold;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (results_taken == 24) hold = LongHold;
			else if ((results_taken / 10) % 3 == 1) hold = 0;
			else hold = $urandom_range(0, 19);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			results_taken++;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = '0;
		last_char = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_text("-");
		send_text("+");
		send_text("0");
		send_text("0x");
		send_text("0o");
		send_text("05");
		send_text("1__2");
		send_text("_1");
		send_text("1_");
		send_text("+1-");
		send_text("0xaF");
		token = '{8'hff};
		send_token();
		await_drain();

		while (chars_sent < CharBudget) begin
			if (!paused && chars_sent >= CharBudget / 2) begin
				paused = 1'b1;
				await_drain();
			end
			compose_token();
			send_token();
		end
		await_drain();
		repeat (20) @(posedge clk);

		if (mismatch_count == 0) $display("integer_literal_parser regression: pass");
		else $display("integer_literal_parser regression: fail");
		$finish;
	end

endmodule
